[hw/rtl/fpse_pkg.sv]
`default_nettype none

package fpse_pkg;

  localparam int WORD_BITS   = 32;
  localparam int COUNT_BITS  = $clog2(WORD_BITS);
  localparam int LEN_BITS    = COUNT_BITS + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam int MANT_W  = 5;
  localparam int LIMIT_W = 4;
  localparam int CFG_W   = 6;
  localparam int INDEX_W = 2;

  localparam logic [MANT_W-1:0]  MANT_RESET  = 5'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;
  localparam logic [CFG_W-1:0]   LEN_RESET   = 6'd12;

  localparam logic [MANT_W-1:0]  MANT_MIN = 5'd1;
  localparam logic [MANT_W-1:0]  MANT_MAX = 5'd24;
  localparam logic [CFG_W-1:0]   LEN_MIN  = 6'd1;
  localparam logic [CFG_W-1:0]   LEN_MAX  = 6'd32;

  typedef enum logic [INDEX_W-1:0] {
    REG_MANTISSA_BITS  = 2'd0,
    REG_EXPONENT_LIMIT = 2'd1,
    REG_CODE_LENGTH    = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_MARK   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CODE   = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_MARK   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [WORD_BITS-1:0]  code;
    logic [LEN_BITS-1:0]   len;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/fpse_front.sv]
`default_nettype none

module fpse_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [fpse_pkg::INDEX_W-1:0]       cfg_index,
  input  wire logic [fpse_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                               opcode,
  input  wire logic [fpse_pkg::WORD_BITS-1:0]     value_fraction,
  output fpse_pkg::entry_t                        entry
);

  logic [fpse_pkg::MANT_W-1:0]  mantissa_bits;
  logic [fpse_pkg::LIMIT_W-1:0] exponent_limit;
  logic [fpse_pkg::CFG_W-1:0]   code_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      mantissa_bits  <= fpse_pkg::MANT_RESET;
      exponent_limit <= fpse_pkg::LIMIT_RESET;
      code_length    <= fpse_pkg::LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fpse_pkg::REG_MANTISSA_BITS:  mantissa_bits  <= cfg_data[fpse_pkg::MANT_W-1:0];
        fpse_pkg::REG_EXPONENT_LIMIT: exponent_limit <= cfg_data[fpse_pkg::LIMIT_W-1:0];
        fpse_pkg::REG_CODE_LENGTH:    code_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [fpse_pkg::MANT_W-1:0] m;
  logic [fpse_pkg::CFG_W-1:0]  l;
  logic [4:0]  s;
  logic [4:0]  sm1;
  logic [4:0]  z;
  logic [4:0]  z_adj;
  logic [31:0] n;
  logic [31:0] src;
  logic [31:0] q_raw;
  logic [31:0] lo_mask;
  logic [24:0] q_inc;
  logic [24:0] q_fin;
  logic [24:0] top;
  logic        guard;
  logic        sticky;
  logic        up;
  logic        ovf;
  logic        reject;
  logic        normal;
  logic [31:0] code;
  logic [31:0] len_mask;

  always_comb begin
    m = mantissa_bits;
    if (m < fpse_pkg::MANT_MIN) m = fpse_pkg::MANT_MIN;
    if (m > fpse_pkg::MANT_MAX) m = fpse_pkg::MANT_MAX;
    l = code_length;
    if (l < fpse_pkg::LEN_MIN) l = fpse_pkg::LEN_MIN;
    if (l > fpse_pkg::LEN_MAX) l = fpse_pkg::LEN_MAX;

    s   = 5'(6'd32 - {1'b0, m});
    sm1 = s - 5'd1;
    normal = (exponent_limit != '0);

    z = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (value_fraction[i]) z = 5'(31 - i);
    end
    n = value_fraction << z;

    src     = normal ? n : value_fraction;
    q_raw   = src >> s;
    guard   = src[sm1];
    lo_mask = (32'h1 << sm1) - 32'h1;
    sticky  = |(src & lo_mask);
    up      = normal ? (guard & (sticky | q_raw[0])) : guard;
    q_inc   = q_raw[24:0] + 25'(up);
    top     = 25'h1 << m;
    ovf     = (q_inc == top);

    z_adj = z;
    q_fin = q_inc;
    if (normal && ovf) begin
      z_adj = z - 5'd1;
      q_fin = top >> 1;
    end

    if (normal) begin
      if (value_fraction == '0) begin
        reject = 1'b0;
        code   = '0;
      end else begin
        reject = (ovf && z == 5'd0) || (z_adj > {1'b0, exponent_limit});
        code   = (32'(z_adj) << m) | 32'(q_fin);
      end
    end else begin
      reject = ovf;
      code   = 32'(q_inc);
    end

    len_mask = ~(32'hFFFF_FFFF << l);

    entry.code = code & len_mask;
    entry.len  = l;
    if (opcode == fpse_pkg::OP_MARK) begin
      entry.kind = fpse_pkg::KIND_MARK;
    end else if (reject) begin
      entry.kind = fpse_pkg::KIND_REJECT;
    end else begin
      entry.kind = fpse_pkg::KIND_CODE;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fpse_queue.sv]
`default_nettype none

module fpse_queue #(
  parameter int DEPTH = fpse_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fpse_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   nonempty,
  output fpse_pkg::entry_t       head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpse_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fpse_back.sv]
`default_nettype none

module fpse_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             head_valid,
  input  wire fpse_pkg::entry_t                 head,
  output logic                                  pop,
  output logic                                  word_valid,
  input  wire logic                             word_stall,
  output logic [fpse_pkg::WORD_BITS-1:0]        packed_word,
  output logic                                  status,
  output logic                                  last
);

  localparam int W  = fpse_pkg::WORD_BITS;
  localparam int CW = fpse_pkg::COUNT_BITS;
  localparam int TW = CW + 2;

  logic [W-1:0]  partial_word;
  logic [W-1:0]  partial_word_next;
  logic [CW-1:0] bit_count;
  logic [CW-1:0] bit_count_next;
  logic          word_valid_next;
  logic          emit;
  logic [W-1:0]  emit_word;
  logic          emit_status;
  logic          emit_last;
  logic [TW-1:0] total;
  logic [TW-1:0] shift;
  logic [2*W-1:0] acc;

  assign pop = head_valid && (!word_valid || !word_stall);

  always_comb begin
    partial_word_next = partial_word;
    bit_count_next    = bit_count;
    emit        = 1'b0;
    emit_word   = '0;
    emit_status = 1'b0;
    emit_last   = 1'b0;
    total = TW'(bit_count) + TW'(head.len);
    shift = TW'(2 * W) - total;
    acc   = {partial_word, {W{1'b0}}} | ({{W{1'b0}}, head.code} << shift);

    if (pop) begin
      unique case (head.kind)
        fpse_pkg::KIND_MARK: begin
          if (bit_count != '0) begin
            emit      = 1'b1;
            emit_word = partial_word;
            emit_last = 1'b1;
            partial_word_next = '0;
            bit_count_next    = '0;
          end
        end
        fpse_pkg::KIND_REJECT: begin
          emit        = 1'b1;
          emit_status = 1'b1;
        end
        fpse_pkg::KIND_CODE: begin
          if (total >= TW'(W)) begin
            emit              = 1'b1;
            emit_word         = acc[2*W-1:W];
            partial_word_next = acc[W-1:0];
            bit_count_next    = CW'(total - TW'(W));
          end else begin
            partial_word_next = acc[2*W-1:W];
            bit_count_next    = CW'(total);
          end
        end
        default: ;
      endcase
    end

    word_valid_next = word_valid && word_stall;
    if (emit) word_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= '0;
      bit_count    <= '0;
      word_valid   <= 1'b0;
    end else begin
      partial_word <= partial_word_next;
      bit_count    <= bit_count_next;
      word_valid   <= word_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packed_word <= emit_word;
      status      <= emit_status;
      last        <= emit_last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fraction_pack_stream_encoder_top.sv]
// Requests pass through the queue to the packer, which registers each completed output word.
// One request per cycle while the queue has room; code forming is combinational.
// A queue of QUEUE_DEPTH entries sits between the code former and the word packer.
// Reset (rst, synchronous, active high) empties the queue and the output register,
// clears the partial word and bit count, and loads the register defaults.
`default_nettype none

module fraction_pack_stream_encoder_top #(
  parameter int QUEUE_DEPTH = fpse_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [fpse_pkg::INDEX_W-1:0]     cfg_index,
  input  wire logic [fpse_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic                             opcode,
  input  wire logic [fpse_pkg::WORD_BITS-1:0]   value_fraction,
  output logic                                  word_valid,
  input  wire logic                             word_stall,
  output logic [fpse_pkg::WORD_BITS-1:0]        packed_word,
  output logic                                  status,
  output logic                                  last
);

  fpse_pkg::entry_t front_entry;
  fpse_pkg::entry_t head;
  logic             full;
  logic             nonempty;
  logic             pop;
  logic             push;

  assign item_stall = full;
  assign push       = item_valid && !full;

  fpse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .value_fraction (value_fraction),
    .entry          (front_entry)
  );

  fpse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .nonempty   (nonempty),
    .head       (head)
  );

  fpse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (nonempty),
    .head        (head),
    .pop         (pop),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .packed_word (packed_word),
    .status      (status),
    .last        (last)
  );

endmodule

`default_nettype wire

[dv/tb_fraction_pack_stream_encoder_top.sv]
`timescale 1ns / 1ps

module tb_fraction_pack_stream_encoder_top;
  import fpse_pkg::*;

  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
  localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 status;
    logic                 last;
  } word_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 opcode = OP_ENCODE;
  logic [WORD_BITS-1:0] value_fraction = '0;
  logic                 word_valid;
  logic                 word_stall = 1'b0;
  logic [WORD_BITS-1:0] packed_word;
  logic                 status;
  logic                 last;

  logic                 word_hold = 1'b0;
  int                   idle_pct = 0;
  int                   stall_pct = 0;

  logic [MANT_W-1:0]    enc_mant;
  logic [LIMIT_W-1:0]   enc_limit;
  logic [CFG_W-1:0]     enc_len;
  logic [WORD_BITS-1:0] pack_word;
  int unsigned          pack_count;

  word_result_t         expected_words[$];
  int                   mismatch_count = 0;
  int                   requests_sent = 0;
  int                   words_checked = 0;
  int                   settings_applied = 0;

  fraction_pack_stream_encoder_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .value_fraction (value_fraction),
    .word_valid     (word_valid),
    .word_stall     (word_stall),
    .packed_word    (packed_word),
    .status         (status),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout at %0t with %0d words outstanding", $time, expected_words.size());
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    word_stall <= word_hold || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    word_result_t want;
    if (!rst && word_valid && !word_stall) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected word: expected none, actual word %h status %b last %b",
                 $time, packed_word, status, last);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (packed_word !== want.word) begin
          mismatch_count++;
          $display("%0t packed_word: expected %h, actual %h", $time, want.word, packed_word);
        end
        if (status !== want.status) begin
          mismatch_count++;
          $display("%0t status: expected %b, actual %b", $time, want.status, status);
        end
        if (last !== want.last) begin
          mismatch_count++;
          $display("%0t last: expected %b, actual %b", $time, want.last, last);
        end
      end
    end
  end

  function automatic int unsigned eff_mant();
    if (enc_mant < MANT_MIN) return 32'(MANT_MIN);
    if (enc_mant > MANT_MAX) return 32'(MANT_MAX);
    return 32'(enc_mant);
  endfunction

  function automatic int unsigned eff_len();
    if (enc_len < LEN_MIN) return 32'(LEN_MIN);
    if (enc_len > LEN_MAX) return 32'(LEN_MAX);
    return 32'(enc_len);
  endfunction

  function automatic bit form_code(input logic [31:0] v, input int unsigned m,
                                   input int unsigned k, output logic [31:0] code);
    int unsigned s;
    int unsigned z;
    logic [63:0] half;
    logic [63:0] rmask;
    logic [63:0] top;
    logic [63:0] q;
    logic [63:0] r;
    logic [31:0] n;
    s = 32 - m;
    half = 64'd1 << (s - 1);
    rmask = (64'd1 << s) - 64'd1;
    top = 64'd1 << m;
    code = '0;
    if (k != 0) begin
      if (v == 0) return 1'b1;
      z = 0;
      while (z < 32 && !v[31-z]) z++;
      n = v << z;
      q = {32'd0, n} >> s;
      r = {32'd0, n} & rmask;
      if (r > half || (r == half && q[0])) q++;
      if (q == top) begin
        if (z == 0) return 1'b0;
        z--;
        q = top >> 1;
      end
      if (z > k) return 1'b0;
      code = 32'((64'(z) << m) | q);
      return 1'b1;
    end
    q = {32'd0, v} >> s;
    r = {32'd0, v} & rmask;
    if (r >= half) q++;
    if (q == top) return 1'b0;
    code = q[31:0];
    return 1'b1;
  endfunction

  task automatic predict_request(input opcode_t op, input logic [31:0] v);
    logic [31:0]  code;
    logic [63:0]  acc;
    int unsigned  l;
    int unsigned  total;
    if (op == OP_MARK) begin
      if (pack_count != 0) expected_words.push_back({pack_word, 1'b0, 1'b1});
      pack_word = '0;
      pack_count = 0;
      return;
    end
    l = eff_len();
    if (!form_code(v, eff_mant(), 32'(enc_limit), code)) begin
      expected_words.push_back({32'd0, 1'b1, 1'b0});
      return;
    end
    if (l < 32) code = code & ((32'd1 << l) - 32'd1);
    total = pack_count + l;
    acc = {pack_word, 32'd0} | ({32'd0, code} << (64 - total));
    if (total >= WORD_BITS) begin
      expected_words.push_back({acc[63:32], 1'b0, 1'b0});
      pack_word = acc[31:0];
      pack_count = total - WORD_BITS;
    end else begin
      pack_word = acc[63:32];
      pack_count = total;
    end
  endtask

  task automatic send_request(input opcode_t op, input logic [31:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    value_fraction <= v;
    do @(posedge clk); while (item_stall);
    predict_request(op, v);
    requests_sent++;
  endtask

  task automatic drain_words();
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_MANTISSA_BITS:  enc_mant = data[MANT_W-1:0];
      REG_EXPONENT_LIMIT: enc_limit = data[LIMIT_W-1:0];
      REG_CODE_LENGTH:    enc_len = data;
      default: ;
    endcase
  endtask

  task automatic write_registers(input logic [CFG_W-1:0] mant_data,
                                 input logic [CFG_W-1:0] limit_data,
                                 input logic [CFG_W-1:0] len_data);
    logic [31:0] noise;
    noise = $urandom;
    drain_words();
    cfg_put(REG_MANTISSA_BITS, mant_data);
    cfg_put(REG_EXPONENT_LIMIT, limit_data);
    cfg_put(REG_CODE_LENGTH, len_data);
    cfg_put(REG_UNUSED, noise[CFG_W-1:0]);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  task automatic pick_setting();
    logic [31:0]        r;
    logic [MANT_W-1:0]  m;
    logic [LIMIT_W-1:0] k;
    logic [CFG_W-1:0]   l;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: m = MANT_MIN;
      1: m = MANT_MAX;
      2: m = '0;
      3: m = MANT_W'($urandom_range(25, 31));
      default: m = MANT_W'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 3))
      0: k = '0;
      1: k = '1;
      default: k = LIMIT_W'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 5))
      0: l = LEN_MIN;
      1: l = LEN_MAX;
      2: l = '0;
      3: l = CFG_W'($urandom_range(33, 63));
      default: l = CFG_W'($urandom_range(1, 32));
    endcase
    write_registers({r[0], m}, {r[2:1], k}, l);
  endtask

  function automatic logic [31:0] random_fraction();
    logic [31:0]  v;
    logic [31:0]  half;
    logic [31:0]  rmask;
    int unsigned  s;
    s = 32 - eff_mant();
    half = 32'd1 << (s - 1);
    rmask = (s == 32) ? 32'hFFFF_FFFF : ((32'd1 << s) - 32'd1);
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = v >> $urandom_range(0, 31);
      1, 2: begin
        v = (v & ~rmask) | (half + 32'($urandom_range(0, 2)) - 32'd1);
        if (enc_limit != 0) v = (v | 32'h8000_0000) >> $urandom_range(0, 3);
      end
      3: v = 32'hFFFF_FFFF >> $urandom_range(0, 16);
      4: v = 32'($urandom_range(0, 1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 8) send_request(OP_MARK, $urandom);
      else send_request(OP_ENCODE, random_fraction());
    end
  endtask

  task automatic test_default_setting();
    send_request(OP_ENCODE, 32'h0000_0000);
    send_request(OP_ENCODE, 32'hFFFF_FFFF);
    send_request(OP_ENCODE, 32'h8000_0000);
    send_request(OP_ENCODE, 32'h0000_0001);
    send_request(OP_ENCODE, 32'h2000_0000);
    send_request(OP_ENCODE, 32'h1000_0000);
    send_request(OP_ENCODE, 32'h8020_0000);
    send_request(OP_ENCODE, 32'h8060_0000);
    send_request(OP_ENCODE, 32'h3FFF_FFFF);
    send_request(OP_MARK, 32'hFFFF_FFFF);
    send_request(OP_MARK, 32'h0000_0000);
    drain_words();
  endtask

  task automatic test_plain_fraction();
    write_registers(6'd8, 6'd0, 6'd8);
    send_request(OP_ENCODE, 32'h0000_0000);
    send_request(OP_ENCODE, 32'hFF80_0000);
    send_request(OP_ENCODE, 32'hFF7F_FFFF);
    send_request(OP_ENCODE, 32'h0080_0000);
    send_request(OP_MARK, 32'h0000_0000);
    drain_words();
  endtask

  task automatic test_register_extremes();
    write_registers(6'd0, 6'd15, 6'd0);
    send_request(OP_ENCODE, 32'h8000_0000);
    send_request(OP_ENCODE, 32'hC000_0000);
    send_request(OP_MARK, 32'h0000_0000);
    write_registers(6'd63, 6'd63, 6'd63);
    send_request(OP_ENCODE, 32'h0000_0001);
    send_request(OP_ENCODE, 32'h0001_0000);
    write_registers(6'd24, 6'd15, 6'd4);
    send_request(OP_ENCODE, 32'h5A5A_5A5A);
    send_request(OP_MARK, 32'h0000_0000);
    write_registers(6'd24, 6'd0, 6'd32);
    send_request(OP_ENCODE, 32'hFFFF_FFFF);
    send_request(OP_ENCODE, 32'h1234_5678);
    drain_words();
  endtask

  task automatic test_random_traffic();
    int idle_table[4];
    int stall_table[4];
    idle_table = '{0, 85, 0, 6};
    stall_table = '{0, 0, 85, 6};
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        pick_setting();
        idle_pct = idle_table[p];
        stall_pct = stall_table[p];
        send_random(60);
      end
      drain_words();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    write_registers(6'd20, 6'd8, 6'd32);
    fork
      begin
        word_hold <= 1'b1;
        repeat (300) @(posedge clk);
        word_hold <= 1'b0;
      end
      send_random(60);
    join
    drain_words();
  endtask

  initial begin
    enc_mant = MANT_RESET;
    enc_limit = LIMIT_RESET;
    enc_len = LEN_RESET;
    pack_word = '0;
    pack_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_setting();
    test_plain_fraction();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    drain_words();
    repeat (20) @(posedge clk);
    $display("sent %0d requests over %0d register settings, checked %0d words",
             requests_sent, settings_applied, words_checked);
    $display("phases: free flow, sparse sender, heavy output stall, light both, long hold-off");
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fpse_pkg.sv
hw/rtl/fpse_front.sv
hw/rtl/fpse_queue.sv
hw/rtl/fpse_back.sv
hw/rtl/fraction_pack_stream_encoder_top.sv
dv/tb_fraction_pack_stream_encoder_top.sv
